>>> src/mspc_pkg.sv
`default_nettype none

package mspc_pkg;

    localparam int GAIN_W      = 16;
    localparam int LIMIT_W     = 15;
    localparam int INTEG_W     = 16;
    localparam int DRIVE_W     = 16;
    localparam int CFG_ADDR_W  = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int OUT_DATA_W  = ((DRIVE_W + 1 + 7) / 8) * 8;

    // register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_MODE           = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_INC_KP         = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_INC_KI         = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_POS_KP         = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_POS_KI         = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_POS_KD         = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] REG_PWM_LIMIT      = 3'd6;
    localparam logic [CFG_ADDR_W-1:0] REG_INTEGRAL_LIMIT = 3'd7;

    // controller modes
    localparam logic MODE_INC = 1'b0;
    localparam logic MODE_POS = 1'b1;

    // reset values
    localparam logic signed [GAIN_W-1:0] RST_POS_KP         = 16'sd20;
    localparam logic signed [GAIN_W-1:0] RST_POS_KI         = 16'sd5;
    localparam logic signed [GAIN_W-1:0] RST_POS_KD         = 16'sd0;
    localparam logic [LIMIT_W-1:0]       RST_PWM_LIMIT      = 15'd989;
    localparam logic [LIMIT_W-1:0]       RST_INTEGRAL_LIMIT = 15'd500;

    typedef struct packed {
        logic                       mode;
        logic signed [GAIN_W-1:0]   inc_kp;
        logic signed [GAIN_W-1:0]   inc_ki;
        logic signed [GAIN_W-1:0]   pos_kp;
        logic signed [GAIN_W-1:0]   pos_ki;
        logic signed [GAIN_W-1:0]   pos_kd;
        logic [LIMIT_W-1:0]         pwm_limit;
        logic [LIMIT_W-1:0]         integral_limit;
    } t_cfg;

    typedef struct packed {
        logic signed [DRIVE_W-1:0]  drive;
        logic                       clamped;
    } t_drive;

endpackage

`default_nettype wire

>>> src/mspc_cfg_regs.sv
`default_nettype none

module mspc_cfg_regs (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_we,
    input  wire logic [mspc_pkg::CFG_ADDR_W-1:0]    i_cfg_addr,
    input  wire logic [mspc_pkg::CFG_DATA_W-1:0]    i_cfg_wdata,
    output mspc_pkg::t_cfg                          o_cfg
);

    mspc_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mode           <= mspc_pkg::MODE_INC;
            r_cfg.inc_kp         <= '0;
            r_cfg.inc_ki         <= '0;
            r_cfg.pos_kp         <= mspc_pkg::RST_POS_KP;
            r_cfg.pos_ki         <= mspc_pkg::RST_POS_KI;
            r_cfg.pos_kd         <= mspc_pkg::RST_POS_KD;
            r_cfg.pwm_limit      <= mspc_pkg::RST_PWM_LIMIT;
            r_cfg.integral_limit <= mspc_pkg::RST_INTEGRAL_LIMIT;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                mspc_pkg::REG_MODE:           r_cfg.mode   <= i_cfg_wdata[0];
                mspc_pkg::REG_INC_KP:         r_cfg.inc_kp <= i_cfg_wdata;
                mspc_pkg::REG_INC_KI:         r_cfg.inc_ki <= i_cfg_wdata;
                mspc_pkg::REG_POS_KP:         r_cfg.pos_kp <= i_cfg_wdata;
                mspc_pkg::REG_POS_KI:         r_cfg.pos_ki <= i_cfg_wdata;
                mspc_pkg::REG_POS_KD:         r_cfg.pos_kd <= i_cfg_wdata;
                mspc_pkg::REG_PWM_LIMIT: begin
                    r_cfg.pwm_limit <= i_cfg_wdata[mspc_pkg::LIMIT_W-1:0];
                end
                mspc_pkg::REG_INTEGRAL_LIMIT: begin
                    r_cfg.integral_limit <= i_cfg_wdata[mspc_pkg::LIMIT_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

>>> src/mspc_inc_pi.sv
`default_nettype none

module mspc_inc_pi #(
    parameter int SAMPLE_WIDTH   = 16,
    parameter int GAIN_FRAC_BITS = 8,
    parameter int ACC_WIDTH      = 48
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire logic                                   i_step,
    input  wire logic signed [SAMPLE_WIDTH:0]           i_error,
    input  wire logic signed [mspc_pkg::GAIN_W-1:0]     i_kp,
    input  wire logic signed [mspc_pkg::GAIN_W-1:0]     i_ki,
    input  wire logic [mspc_pkg::LIMIT_W-1:0]           i_pwm_limit,
    output mspc_pkg::t_drive                            o_res
);

    localparam int EW   = SAMPLE_WIDTH + 1;
    localparam int PW   = SAMPLE_WIDTH + 2;
    localparam int PPW  = mspc_pkg::GAIN_W + PW;
    localparam int PIW  = mspc_pkg::GAIN_W + EW;
    localparam int IW   = PPW + 1;
    localparam int SUMW = ((IW > ACC_WIDTH) ? IW : ACC_WIDTH) + 1;

    logic signed [ACC_WIDTH-1:0] r_acc;
    logic signed [ACC_WIDTH-1:0] n_acc;
    logic signed [PW-1:0]        r_prev;

    logic signed [PW-1:0]        w_err_x;
    logic signed [PW-1:0]        w_diff;
    logic signed [PPW-1:0]       w_prod_p;
    logic signed [PIW-1:0]       w_prod_i;
    logic signed [SUMW-1:0]      w_inc;
    logic signed [SUMW-1:0]      w_sum;
    logic                        w_fits;
    logic                        w_neg;
    logic [ACC_WIDTH-1:0]        w_mag;
    logic [ACC_WIDTH-1:0]        w_q;
    logic                        w_hit;
    logic [mspc_pkg::LIMIT_W-1:0] w_qc;

    assign w_err_x  = {{(PW-EW){i_error[EW-1]}}, i_error};
    assign w_diff   = w_err_x - r_prev;
    assign w_prod_p = i_kp * w_diff;
    assign w_prod_i = i_ki * i_error;
    assign w_inc    = SUMW'(w_prod_p) + SUMW'(w_prod_i);
    assign w_sum    = SUMW'(r_acc) + w_inc;

    // in range when all bits above the accumulator's sign agree with it
    assign w_fits = (w_sum[SUMW-1:ACC_WIDTH-1] == '0) || (w_sum[SUMW-1:ACC_WIDTH-1] == '1);

    always_comb begin
        if (w_fits) begin
            n_acc = w_sum[ACC_WIDTH-1:0];
        end else begin
            n_acc = {w_sum[SUMW-1], {(ACC_WIDTH-1){~w_sum[SUMW-1]}}};
        end
    end

    // truncate toward zero: shift the magnitude, then restore the sign
    assign w_neg = n_acc[ACC_WIDTH-1];
    assign w_mag = w_neg ? (~n_acc + 1'b1) : n_acc;
    assign w_q   = w_mag >> GAIN_FRAC_BITS;
    assign w_hit = w_q > ACC_WIDTH'(i_pwm_limit);
    assign w_qc  = w_hit ? i_pwm_limit : w_q[mspc_pkg::LIMIT_W-1:0];

    assign o_res.drive   = w_neg ? -$signed({1'b0, w_qc}) : $signed({1'b0, w_qc});
    assign o_res.clamped = w_hit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc  <= '0;
            r_prev <= '0;
        end else if (i_step) begin
            r_acc  <= n_acc;
            r_prev <= w_err_x;
        end
    end

endmodule

`default_nettype wire

>>> src/mspc_pos_pid.sv
`default_nettype none

module mspc_pos_pid #(
    parameter int SAMPLE_WIDTH = 16
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire logic                                   i_step,
    input  wire logic signed [SAMPLE_WIDTH:0]           i_error,
    input  wire logic signed [mspc_pkg::GAIN_W-1:0]     i_kp,
    input  wire logic signed [mspc_pkg::GAIN_W-1:0]     i_ki,
    input  wire logic signed [mspc_pkg::GAIN_W-1:0]     i_kd,
    input  wire logic [mspc_pkg::LIMIT_W-1:0]           i_pwm_limit,
    input  wire logic [mspc_pkg::LIMIT_W-1:0]           i_integral_limit,
    output mspc_pkg::t_drive                            o_res
);

    localparam int EW  = SAMPLE_WIDTH + 1;
    localparam int PW  = SAMPLE_WIDTH + 2;
    localparam int IW  = mspc_pkg::INTEG_W;
    localparam int SNW = ((IW > EW) ? IW : EW) + 1;
    localparam int TPW = mspc_pkg::GAIN_W + EW;
    localparam int TIW = mspc_pkg::GAIN_W + IW;
    localparam int TDW = mspc_pkg::GAIN_W + PW;
    localparam int RW  = ((TDW > TIW) ? TDW : TIW) + 2;
    localparam int DW  = mspc_pkg::DRIVE_W;

    logic signed [IW-1:0]  r_isum;
    logic signed [IW-1:0]  n_isum;
    logic signed [PW-1:0]  r_prev;

    logic signed [PW-1:0]  w_err_x;
    logic signed [PW-1:0]  w_diff;
    logic signed [SNW-1:0] w_s;
    logic signed [SNW-1:0] w_ilim;
    logic signed [TPW-1:0] w_tp;
    logic signed [TIW-1:0] w_ti;
    logic signed [TDW-1:0] w_td;
    logic signed [RW-1:0]  w_raw;
    logic signed [RW-1:0]  w_plim;
    logic signed [DW-1:0]  w_plim_d;

    assign w_err_x = {{(PW-EW){i_error[EW-1]}}, i_error};
    assign w_diff  = w_err_x - r_prev;

    assign w_s    = SNW'(r_isum) + SNW'(i_error);
    assign w_ilim = SNW'({1'b0, i_integral_limit});

    always_comb begin
        if (w_s > w_ilim) begin
            n_isum = w_ilim[IW-1:0];
        end else if (w_s < -w_ilim) begin
            n_isum = IW'(-w_ilim);
        end else begin
            n_isum = w_s[IW-1:0];
        end
    end

    // the integral term uses the freshly clamped sum
    assign w_tp  = i_kp * i_error;
    assign w_ti  = i_ki * n_isum;
    assign w_td  = i_kd * w_diff;
    assign w_raw = RW'(w_tp) + RW'(w_ti) + RW'(w_td);

    assign w_plim   = RW'({1'b0, i_pwm_limit});
    assign w_plim_d = DW'({1'b0, i_pwm_limit});

    always_comb begin
        if (w_raw > w_plim) begin
            o_res.drive   = w_plim_d;
            o_res.clamped = 1'b1;
        end else if (w_raw < -w_plim) begin
            o_res.drive   = -w_plim_d;
            o_res.clamped = 1'b1;
        end else begin
            o_res.drive   = w_raw[DW-1:0];
            o_res.clamped = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_isum <= '0;
            r_prev <= '0;
        end else if (i_step) begin
            r_isum <= n_isum;
            r_prev <= w_err_x;
        end
    end

endmodule

`default_nettype wire

>>> src/motor_speed_pi_pid_control_core.sv
`default_nettype none

// Motor speed controller, one item per control tick. Each input item carries a target
// speed, a measured speed and a run flag; each produces exactly one result item with a
// clamped drive value and a flag saying whether the pwm limit cut it. With run clear the
// drive is zero and no controller state moves. The mode register picks an incremental PI
// (Q8.8 gains, saturating accumulator, drive truncated toward zero) or a positional PID
// with an integral clamped to the integral limit; each mode keeps its own state across
// mode changes. The block takes one item per clock cycle while the downstream is ready:
// the error is formed into an input register, the selected controller updates its state
// and computes the drive combinationally, and the result sits in an output register, so
// throughput follows the downstream ready. Configuration registers are written through
// a plain write port and should only be changed while the block is idle.
module motor_speed_pi_pid_control_core #(
    parameter int SAMPLE_WIDTH   = 16,
    parameter int GAIN_FRAC_BITS = 8,
    parameter int ACC_WIDTH      = 48
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    // slave side: tdata = target_speed, measured_speed, motor_run (lowest bit first)
    input  wire logic                                   i_s_axis_tvalid,
    output      logic                                   o_s_axis_tready,
    input  wire logic [((2*SAMPLE_WIDTH+1+7)/8)*8-1:0]  i_s_axis_tdata,
    // master side: tdata = drive, clamped (lowest bit first)
    output      logic                                   o_m_axis_tvalid,
    input  wire logic                                   i_m_axis_tready,
    output      logic [mspc_pkg::OUT_DATA_W-1:0]        o_m_axis_tdata,
    // configuration write port
    input  wire logic                                   i_cfg_we,
    input  wire logic [mspc_pkg::CFG_ADDR_W-1:0]        i_cfg_addr,
    input  wire logic [mspc_pkg::CFG_DATA_W-1:0]        i_cfg_wdata
);

    localparam int SW = SAMPLE_WIDTH;
    localparam int EW = SAMPLE_WIDTH + 1;

    mspc_pkg::t_cfg   w_cfg;
    mspc_pkg::t_drive w_inc_res;
    mspc_pkg::t_drive w_pos_res;
    mspc_pkg::t_drive r_res;

    logic                 r_in_valid;
    logic                 r_run;
    logic signed [EW-1:0] r_err;
    logic                 r_out_valid;

    logic                 w_out_free;
    logic                 w_advance;
    logic                 w_in_take;
    logic                 w_step;
    logic signed [EW-1:0] w_err;

    logic [SW-1:0]        w_target;
    logic [SW-1:0]        w_measured;

    assign w_target   = i_s_axis_tdata[SW-1:0];
    assign w_measured = i_s_axis_tdata[2*SW-1:SW];
    assign w_err      = $signed({w_target[SW-1], w_target})
                      - $signed({w_measured[SW-1], w_measured});

    assign w_out_free      = !r_out_valid || i_m_axis_tready;
    assign w_advance       = r_in_valid && w_out_free;
    assign o_s_axis_tready = !r_in_valid || w_out_free;
    assign w_in_take       = i_s_axis_tvalid && o_s_axis_tready;
    assign w_step          = w_advance && r_run;

    mspc_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (w_cfg)
    );

    mspc_inc_pi #(
        .SAMPLE_WIDTH   (SAMPLE_WIDTH),
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS),
        .ACC_WIDTH      (ACC_WIDTH)
    ) u_inc (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (w_step && (w_cfg.mode == mspc_pkg::MODE_INC)),
        .i_error     (r_err),
        .i_kp        (w_cfg.inc_kp),
        .i_ki        (w_cfg.inc_ki),
        .i_pwm_limit (w_cfg.pwm_limit),
        .o_res       (w_inc_res)
    );

    mspc_pos_pid #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_pos (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_step           (w_step && (w_cfg.mode == mspc_pkg::MODE_POS)),
        .i_error          (r_err),
        .i_kp             (w_cfg.pos_kp),
        .i_ki             (w_cfg.pos_ki),
        .i_kd             (w_cfg.pos_kd),
        .i_pwm_limit      (w_cfg.pwm_limit),
        .i_integral_limit (w_cfg.integral_limit),
        .o_res            (w_pos_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_s_axis_tready) begin
                r_in_valid <= i_s_axis_tvalid;
            end
            if (w_out_free) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_err <= w_err;
            r_run <= i_s_axis_tdata[2*SW];
        end
        if (w_advance) begin
            if (!r_run) begin
                r_res <= '0;
            end else if (w_cfg.mode == mspc_pkg::MODE_POS) begin
                r_res <= w_pos_res;
            end else begin
                r_res <= w_inc_res;
            end
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {{(mspc_pkg::OUT_DATA_W-mspc_pkg::DRIVE_W-1){1'b0}},
                              r_res.clamped, r_res.drive};

endmodule

`default_nettype wire

>>> bench/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int     IN_W        = ((2*16+1+7)/8)*8;
    localparam int     FRAC_BITS   = 8;
    localparam longint ACC_MAX     = 64'sh0000_7fff_ffff_ffff;
    localparam int     QUIET_LIMIT = 5000;
    localparam int     LONG_HOLD   = 400;

    typedef struct packed {
        logic               motor_run;
        logic signed [15:0] measured_speed;
        logic signed [15:0] target_speed;
    } t_tick;

    localparam int TICK_W = $bits(t_tick);

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            s_tvalid = 1'b0;
    logic [IN_W-1:0]                 s_tdata = '0;
    logic                            o_s_axis_tready;
    logic                            o_m_axis_tvalid;
    logic                            m_tready = 1'b0;
    logic [mspc_pkg::OUT_DATA_W-1:0] o_m_axis_tdata;
    logic                            cfg_we = 1'b0;
    logic [mspc_pkg::CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [mspc_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

    t_tick            pending_ticks[$];
    mspc_pkg::t_drive expected_drives[$];

    // register copy and controller state as the block should hold them
    mspc_pkg::t_cfg cfg_shadow;
    longint         pi_accum, pi_prev_err, pid_integral, pid_prev_err;

    bit idle_on = 1'b1;
    int hold_token = 0;
    int hold_seen = 0;
    int hold_left = 0;
    int src_gap = 0;
    int snk_gap = 0;
    int quiet = 0;
    int n_err = 0;

    motor_speed_pi_pid_control_core DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_we        (cfg_we),
        .i_cfg_addr      (cfg_addr),
        .i_cfg_wdata     (cfg_wdata)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    function automatic void shadow_write(input logic [mspc_pkg::CFG_ADDR_W-1:0] a,
                                         input logic [mspc_pkg::CFG_DATA_W-1:0] d);
        case (a)
            mspc_pkg::REG_MODE:           cfg_shadow.mode = d[0];
            mspc_pkg::REG_INC_KP:         cfg_shadow.inc_kp = d;
            mspc_pkg::REG_INC_KI:         cfg_shadow.inc_ki = d;
            mspc_pkg::REG_POS_KP:         cfg_shadow.pos_kp = d;
            mspc_pkg::REG_POS_KI:         cfg_shadow.pos_ki = d;
            mspc_pkg::REG_POS_KD:         cfg_shadow.pos_kd = d;
            mspc_pkg::REG_PWM_LIMIT:      cfg_shadow.pwm_limit = d[mspc_pkg::LIMIT_W-1:0];
            mspc_pkg::REG_INTEGRAL_LIMIT: begin
                cfg_shadow.integral_limit = d[mspc_pkg::LIMIT_W-1:0];
            end
            default: ;
        endcase
    endfunction

    function automatic mspc_pkg::t_drive controller_step(input t_tick t);
        longint err, inc, acc, raw, lim, mag, q, integ;
        mspc_pkg::t_drive r;
        r.drive = '0;
        r.clamped = 1'b0;
        if (!t.motor_run)
            return r;
        err = longint'(t.target_speed) - longint'(t.measured_speed);
        if (cfg_shadow.mode == mspc_pkg::MODE_INC) begin
            inc = longint'(cfg_shadow.inc_kp) * (err - pi_prev_err)
                + longint'(cfg_shadow.inc_ki) * err;
            acc = pi_accum + inc;
            if (acc > ACC_MAX)
                acc = ACC_MAX;
            else if (acc < -ACC_MAX - 1)
                acc = -ACC_MAX - 1;
            pi_accum = acc;
            pi_prev_err = err;
            // drop fraction bits on the magnitude so the drive truncates toward zero
            mag = (acc < 0) ? -acc : acc;
            q = mag >>> FRAC_BITS;
            if (q > longint'(cfg_shadow.pwm_limit)) begin
                q = longint'(cfg_shadow.pwm_limit);
                r.clamped = 1'b1;
            end
            raw = (acc < 0) ? -q : q;
        end else begin
            lim = longint'(cfg_shadow.integral_limit);
            integ = pid_integral + err;
            if (integ > lim)
                integ = lim;
            if (integ < -lim)
                integ = -lim;
            pid_integral = integ;
            raw = longint'(cfg_shadow.pos_kp) * err
                + longint'(cfg_shadow.pos_ki) * integ
                + longint'(cfg_shadow.pos_kd) * (err - pid_prev_err);
            pid_prev_err = err;
            lim = longint'(cfg_shadow.pwm_limit);
            if (raw > lim) begin
                raw = lim;
                r.clamped = 1'b1;
            end else if (raw < -lim) begin
                raw = -lim;
                r.clamped = 1'b1;
            end
        end
        r.drive = raw[mspc_pkg::DRIVE_W-1:0];
        return r;
    endfunction

    // sender: one item offered at a time, held until accepted
    always @(posedge i_clk) begin : drv
        logic            nxt_valid;
        logic [IN_W-1:0] nxt_data;
        t_tick           t;
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
        end else begin
            nxt_valid = s_tvalid;
            nxt_data = s_tdata;
            if (s_tvalid && o_s_axis_tready) begin
                expected_drives.push_back(controller_step(t_tick'(s_tdata[TICK_W-1:0])));
                nxt_valid = 1'b0;
            end
            if (!nxt_valid) begin
                if (src_gap != 0) begin
                    src_gap--;
                end else if (pending_ticks.size() != 0) begin
                    t = pending_ticks.pop_front();
                    nxt_valid = 1'b1;
                    nxt_data = IN_W'(t);
                    if (idle_on && $urandom_range(0, 7) == 0)
                        src_gap = $urandom_range(1, 7);
                end
            end
            s_tvalid <= nxt_valid;
            s_tdata <= nxt_data;
        end
    end

    // receiver: checks each result item against the oldest expected drive
    always @(posedge i_clk) begin : mon
        mspc_pkg::t_drive   want;
        logic signed [15:0] got_drive;
        logic               got_clamped;
        logic               nxt_ready;
        if (!i_rst_n) begin
            m_tready <= 1'b0;
        end else begin
            if (o_m_axis_tvalid && m_tready) begin
                got_drive = o_m_axis_tdata[mspc_pkg::DRIVE_W-1:0];
                got_clamped = o_m_axis_tdata[mspc_pkg::DRIVE_W];
                if (expected_drives.size() == 0) begin
                    $display("%0t unexpected item: drive %0d clamped %0b",
                             $time, got_drive, got_clamped);
                    n_err++;
                end else begin
                    want = expected_drives.pop_front();
                    if (got_drive !== want.drive) begin
                        $display("%0t drive mismatch: expected %0d actual %0d",
                                 $time, want.drive, got_drive);
                        n_err++;
                    end
                    if (got_clamped !== want.clamped) begin
                        $display("%0t clamped mismatch: expected %0b actual %0b",
                                 $time, want.clamped, got_clamped);
                        n_err++;
                    end
                end
            end
            if (hold_token != hold_seen) begin
                hold_seen = hold_token;
                hold_left = LONG_HOLD;
            end
            if (hold_left != 0) begin
                hold_left--;
                nxt_ready = 1'b0;
            end else if (snk_gap != 0) begin
                snk_gap--;
                nxt_ready = 1'b0;
            end else begin
                nxt_ready = 1'b1;
                if (idle_on && $urandom_range(0, 7) == 0)
                    snk_gap = $urandom_range(1, 7);
            end
            m_tready <= nxt_ready;
        end
    end

    always @(posedge i_clk) begin : wdog
        if ((s_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && m_tready))
            quiet = 0;
        else
            quiet++;
        if (quiet == QUIET_LIMIT) begin
            $display("FAIL motor_speed_pi_pid_control_core");
            $finish;
        end
    end

    task automatic reg_write(input logic [mspc_pkg::CFG_ADDR_W-1:0] a,
                             input logic [mspc_pkg::CFG_DATA_W-1:0] d);
        @(posedge i_clk);
        cfg_we <= 1'b1;
        cfg_addr <= a;
        cfg_wdata <= d;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        shadow_write(a, d);
    endtask

    task automatic send(input int tgt, input int meas, input bit run);
        t_tick t;
        t.target_speed = 16'(tgt);
        t.measured_speed = 16'(meas);
        t.motor_run = run;
        pending_ticks.push_back(t);
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        while (pending_ticks.size() != 0 || s_tvalid || expected_drives.size() != 0)
            @(negedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    function automatic t_tick rand_tick();
        t_tick t;
        int    tv;
        case ($urandom_range(0, 9))
            0, 1: begin
                t.target_speed = 16'($urandom);
                t.measured_speed = 16'($urandom);
            end
            2: begin
                t.target_speed = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
                t.measured_speed = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
            end
            default: begin
                // tracking case: measured close to target
                tv = $urandom_range(0, 4000) - 2000;
                t.target_speed = 16'(tv);
                t.measured_speed = 16'(tv + $urandom_range(0, 80) - 40);
            end
        endcase
        t.motor_run = ($urandom_range(0, 9) != 0);
        return t;
    endfunction

    function automatic logic [15:0] rand_gain(input int span);
        case ($urandom_range(0, 7))
            0:       return 16'h7fff;
            1:       return 16'h8000;
            2:       return 16'($urandom);
            default: return 16'($urandom_range(0, 2*span) - span);
        endcase
    endfunction

    function automatic logic [15:0] rand_limit(input int top);
        case ($urandom_range(0, 7))
            0:       return 16'h0000;
            1:       return 16'hffff;
            2:       return 16'($urandom);
            default: return 16'($urandom_range(0, top));
        endcase
    endfunction

    initial begin : stim
        int c;
        int k;
        cfg_shadow.mode = mspc_pkg::MODE_INC;
        cfg_shadow.inc_kp = '0;
        cfg_shadow.inc_ki = '0;
        cfg_shadow.pos_kp = mspc_pkg::RST_POS_KP;
        cfg_shadow.pos_ki = mspc_pkg::RST_POS_KI;
        cfg_shadow.pos_kd = mspc_pkg::RST_POS_KD;
        cfg_shadow.pwm_limit = mspc_pkg::RST_PWM_LIMIT;
        cfg_shadow.integral_limit = mspc_pkg::RST_INTEGRAL_LIMIT;
        pi_accum = 0;
        pi_prev_err = 0;
        pid_integral = 0;
        pid_prev_err = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // reset gains: incremental mode with zero gains gives zero drive
        send(1000, -1000, 1);
        send(0, 0, 1);
        wait_drained();

        // incremental PI, wide error swings, run clear leaves state alone
        reg_write(mspc_pkg::REG_MODE, 16'hfffe);
        reg_write(mspc_pkg::REG_INC_KP, 16'sd256);
        reg_write(mspc_pkg::REG_INC_KI, 16'sd128);
        reg_write(mspc_pkg::REG_PWM_LIMIT, 16'hffff);
        send(32767, -32768, 0);
        send(0, 0, 1);
        send(32767, -32768, 1);
        send(-32768, 32767, 1);
        send(-32768, 32767, 0);
        send(100, 100, 1);
        wait_drained();

        // small negative accumulator values truncate toward zero
        reg_write(mspc_pkg::REG_INC_KP, 16'sd0);
        reg_write(mspc_pkg::REG_INC_KI, 16'sd1);
        send(0, 1, 1);
        send(0, 3, 1);
        send(5, 0, 1);
        wait_drained();

        // positional PID with a zero drive limit
        reg_write(mspc_pkg::REG_MODE, 16'hffff);
        reg_write(mspc_pkg::REG_POS_KP, 16'sh7fff);
        reg_write(mspc_pkg::REG_POS_KI, 16'sd0);
        reg_write(mspc_pkg::REG_POS_KD, 16'sh8000);
        reg_write(mspc_pkg::REG_PWM_LIMIT, 16'd0);
        reg_write(mspc_pkg::REG_INTEGRAL_LIMIT, 16'hffff);
        send(10, 3, 1);
        send(3, 3, 1);
        send(3, 3, 1);
        wait_drained();

        // integral windup against its limit in both directions
        reg_write(mspc_pkg::REG_POS_KP, 16'sd20);
        reg_write(mspc_pkg::REG_POS_KI, 16'sd5);
        reg_write(mspc_pkg::REG_POS_KD, 16'sd0);
        reg_write(mspc_pkg::REG_PWM_LIMIT, 16'd989);
        reg_write(mspc_pkg::REG_INTEGRAL_LIMIT, 16'd500);
        send(32767, -32768, 1);
        send(32767, -32768, 1);
        send(-32768, 32767, 1);
        send(0, 0, 1);
        send(-32768, -32768, 0);
        wait_drained();

        // back to incremental: its state must have survived
        reg_write(mspc_pkg::REG_MODE, {15'b0, mspc_pkg::MODE_INC});
        send(1, 0, 1);
        send(0, 0, 1);
        wait_drained();

        for (c = 0; c < 8; c++) begin
            idle_on = (c % 3 != 2);
            reg_write(mspc_pkg::REG_MODE,
                      {15'b0, (c % 2 == 1) ? mspc_pkg::MODE_POS : mspc_pkg::MODE_INC});
            reg_write(mspc_pkg::REG_INC_KP, rand_gain(512));
            reg_write(mspc_pkg::REG_INC_KI, rand_gain(512));
            reg_write(mspc_pkg::REG_POS_KP, rand_gain(16));
            reg_write(mspc_pkg::REG_POS_KI, rand_gain(16));
            reg_write(mspc_pkg::REG_POS_KD, rand_gain(16));
            reg_write(mspc_pkg::REG_PWM_LIMIT, rand_limit(4000));
            reg_write(mspc_pkg::REG_INTEGRAL_LIMIT, rand_limit(2000));
            @(negedge i_clk);
            for (k = 0; k < 240; k++) begin
                pending_ticks.push_back(rand_tick());
                // sender stops mid-run until every result is back
                if (c == 5 && k == 124)
                    wait_drained();
            end
            // long receiver stall while the sender keeps offering
            if (c == 2)
                hold_token++;
            wait_drained();
        end

        // push the accumulator far past the drive limit one way, then the other
        idle_on = 1'b0;
        reg_write(mspc_pkg::REG_MODE, {15'b0, mspc_pkg::MODE_INC});
        reg_write(mspc_pkg::REG_INC_KP, 16'sd0);
        reg_write(mspc_pkg::REG_INC_KI, 16'sh7fff);
        reg_write(mspc_pkg::REG_PWM_LIMIT, 16'h7fff);
        @(negedge i_clk);
        for (k = 0; k < 60; k++)
            send(32767, -32768, 1);
        wait_drained();
        for (k = 0; k < 120; k++)
            send(-32768, 32767, 1);
        wait_drained();

        repeat (10) @(posedge i_clk);
        if (n_err == 0)
            $display("PASS motor_speed_pi_pid_control_core");
        else
            $display("FAIL motor_speed_pi_pid_control_core");
        $finish;
    end

endmodule
